>>> rtl/papi_pkg.sv
package papi_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    typedef struct packed {
        logic [31:0] axis_x;
        logic [31:0] axis_y;
        logic [31:0] corner_x;
        logic [31:0] corner_y;
        logic        last_corner;
    } papi_in_t;

    typedef struct packed {
        logic [31:0] proj_min;
        logic [31:0] proj_max;
        logic        axis_zero;
    } papi_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_SQR,
        ST_ROOT,
        ST_DIVMIN,
        ST_DIVMAX,
        ST_OUT
    } papi_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } papi_div_stat_t;

endpackage

>>> rtl/polygon_axis_projection_interval_unit.sv
// Projection interval of a polygon onto an axis.
// Input channel s_*: one item per corner; the axis fields are taken on the
// first corner of each polygon and ignored on later ones. last_corner closes
// the polygon. Result channel m_*: one item per polygon with proj_min,
// proj_max (Q16.16, saturated) and axis_zero.
// Per corner, a bit-serial multiply-accumulate forms the dot product one
// multiplier bit per cycle. A last corner then runs the axis squares on the
// same unit, the digit-by-digit square root, and two passes through the
// serial divider, one per bound (the divider is skipped for a zero-length
// axis). One item is worked on at a time.
// The result waits in an output register; a new polygon may start while it
// waits, but the next result is held back until the receiver takes it.
// Reset (aresetn low, synchronous) drops any item in flight, clears the
// output valid, and arms the block for the first corner of a new polygon.
module polygon_axis_projection_interval_unit import papi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  papi_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output papi_out_t m_data
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 1;
    localparam int CW = $clog2(2 * W);

    papi_state_t state_reg, state_next;

    logic [W-1:0]         ax_reg, ay_reg;
    logic                 first_reg;
    logic                 last_reg;
    logic [CW-1:0]        cnt_reg;

    // multiply-accumulate
    logic signed [DW-1:0] mc_a_reg, mc_b_reg;
    logic [W-1:0]         mp_a_reg, mp_b_reg;
    logic signed [DW-1:0] acc_reg, acc_next;
    logic signed [DW-1:0] term_a, term_b;

    logic signed [DW-1:0] min_reg, max_reg;

    // square root
    logic [2*W-1:0]       sq_reg;
    logic [W:0]           rem_reg;
    logic [W-1:0]         root_reg, root_next;
    logic [W+2:0]         rem_sh, trial;
    logic                 rt_ge;

    logic [W-1:0]         len_reg;
    logic [31:0]          res_min_reg;
    logic                 zero_reg;
    logic                 m_valid_reg;
    papi_out_t            m_data_reg;

    logic                 cnt_last_w;
    logic                 out_free;
    logic                 div_start;
    logic [2*W-1:0]       div_dividend;
    logic [W-1:0]         div_divisor;
    logic [2*W-1:0]       div_q;
    papi_div_stat_t       div_stat;

    logic [W-1:0]         in_ax, in_ay, sel_ax, sel_ay;

    function automatic logic signed [DW-1:0] sext(logic [W-1:0] v);
        return {{(DW - W){v[W-1]}}, v};
    endfunction

    function automatic logic [2*W-1:0] mag(logic signed [DW-1:0] d);
        logic [DW-1:0] n;
        n = d[DW-1] ? (~d + 1'b1) : d;
        return n[2*W-1:0];
    endfunction

    // clamp quotient to the signed W-bit range, then sign-extend to 32 bits
    function automatic logic [31:0] sat_q(logic [2*W-1:0] q, logic neg);
        logic [2*W-1:0] lim;
        logic [W-1:0]   r;
        lim = (2 * W)'(1) << (W - 1);
        if (neg) begin
            r = (q > lim) ? {1'b1, {(W - 1){1'b0}}} : (~q[W-1:0] + 1'b1);
        end else begin
            r = (q >= lim) ? {1'b0, {(W - 1){1'b1}}} : q[W-1:0];
        end
        return 32'(signed'(r));
    endfunction

    assign in_ax  = s_data.axis_x[W-1:0];
    assign in_ay  = s_data.axis_y[W-1:0];
    assign sel_ax = first_reg ? in_ax : ax_reg;
    assign sel_ay = first_reg ? in_ay : ay_reg;

    assign cnt_last_w = (cnt_reg == CW'(W - 1));
    assign out_free   = !m_valid_reg || m_ready;

    // multiplier bit W-1 carries negative weight
    assign term_a   = mp_a_reg[0] ? mc_a_reg : '0;
    assign term_b   = mp_b_reg[0] ? mc_b_reg : '0;
    assign acc_next = cnt_last_w ? (acc_reg - term_a - term_b)
                                 : (acc_reg + term_a + term_b);

    // two radicand bits per cycle
    assign rem_sh    = {rem_reg, sq_reg[2*W-1:2*W-2]};
    assign trial     = {2'b00, root_reg, 1'b0} << 1 | (W + 3)'(1);
    assign rt_ge     = (rem_sh >= trial);
    assign root_next = {root_reg[W-2:0], rt_ge};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DOT;
            ST_DOT:    if (cnt_last_w) state_next = last_reg ? ST_SQR : ST_IDLE;
            ST_SQR:    if (cnt_last_w) state_next = ST_ROOT;
            ST_ROOT:   if (cnt_last_w) state_next = (root_next == '0) ? ST_OUT : ST_DIVMIN;
            ST_DIVMIN: if (div_stat.done) state_next = ST_DIVMAX;
            ST_DIVMAX: if (div_stat.done) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        div_start    = 1'b0;
        div_dividend = mag(min_reg);
        div_divisor  = root_next;
        unique case (state_reg)
            ST_ROOT: begin
                div_start = cnt_last_w && (root_next != '0);
            end
            ST_DIVMIN: begin
                div_start    = div_stat.done;
                div_dividend = mag(max_reg);
                div_divisor  = len_reg;
            end
            default: begin
                div_divisor = len_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            first_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            // raise on a new result, drop once the receiver takes it
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                end
                ST_DOT: begin
                    cnt_reg <= cnt_last_w ? '0 : cnt_reg + 1'b1;
                    if (cnt_last_w) first_reg <= 1'b0;
                end
                ST_SQR, ST_ROOT: begin
                    cnt_reg <= cnt_last_w ? '0 : cnt_reg + 1'b1;
                end
                ST_OUT: begin
                    if (out_free) begin
                        first_reg <= 1'b1;
                    end
                end
                default: begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ax_reg   <= sel_ax;
                    ay_reg   <= sel_ay;
                    last_reg <= s_data.last_corner;
                    mc_a_reg <= sext(sel_ax);
                    mc_b_reg <= sext(sel_ay);
                    mp_a_reg <= s_data.corner_x[W-1:0];
                    mp_b_reg <= s_data.corner_y[W-1:0];
                    acc_reg  <= '0;
                end
            end
            ST_DOT: begin
                if (cnt_last_w) begin
                    // fold this corner into the running extremes
                    if (first_reg || acc_next < min_reg) min_reg <= acc_next;
                    if (first_reg || acc_next > max_reg) max_reg <= acc_next;
                    // reload for the axis squares
                    mc_a_reg <= sext(ax_reg);
                    mc_b_reg <= sext(ay_reg);
                    mp_a_reg <= ax_reg;
                    mp_b_reg <= ay_reg;
                    acc_reg  <= '0;
                end else begin
                    mc_a_reg <= mc_a_reg <<< 1;
                    mc_b_reg <= mc_b_reg <<< 1;
                    mp_a_reg <= mp_a_reg >> 1;
                    mp_b_reg <= mp_b_reg >> 1;
                    acc_reg  <= acc_next;
                end
            end
            ST_SQR: begin
                mc_a_reg <= mc_a_reg <<< 1;
                mc_b_reg <= mc_b_reg <<< 1;
                mp_a_reg <= mp_a_reg >> 1;
                mp_b_reg <= mp_b_reg >> 1;
                acc_reg  <= acc_next;
                if (cnt_last_w) begin
                    sq_reg   <= acc_next[2*W-1:0];
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            ST_ROOT: begin
                sq_reg   <= sq_reg << 2;
                rem_reg  <= rt_ge ? (W + 1)'(rem_sh - trial) : rem_sh[W:0];
                root_reg <= root_next;
                if (cnt_last_w) begin
                    len_reg     <= root_next;
                    zero_reg    <= (root_next == '0);
                    res_min_reg <= '0;
                end
            end
            ST_DIVMIN: begin
                if (div_stat.done) res_min_reg <= sat_q(div_q, min_reg[DW-1]);
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg.proj_min  <= zero_reg ? 32'd0 : res_min_reg;
                    m_data_reg.proj_max  <= zero_reg ? 32'd0
                                                     : sat_q(div_q, max_reg[DW-1]);
                    m_data_reg.axis_zero <= zero_reg;
                end
            end
            default: begin
            end
        endcase
    end

    papi_serial_div #(
        .W (W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIVMIN || state_reg == ST_DIVMAX))
        else $error("divider finished outside a divide state");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

    a_zero_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.axis_zero) |->
            (m_data_reg.proj_min == 32'd0 && m_data_reg.proj_max == 32'd0))
        else $error("zero-length axis with nonzero interval");
`endif

endmodule

>>> rtl/papi_serial_div.sv
module papi_serial_div import papi_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [2*W-1:0]   dividend,
    input  logic [W-1:0]     divisor,
    output logic [2*W-1:0]   quotient,
    output papi_div_stat_t   stat
);

    localparam int CW = $clog2(2 * W);

    logic [2*W-1:0] dvd_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   dsr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [W:0]     r_sh;
    logic           ge;
    logic           cnt_end;

    // one quotient bit per cycle, restoring
    assign r_sh    = {rem_reg, dvd_reg[2*W-1]};
    assign ge      = (r_sh >= {1'b0, dsr_reg});
    assign cnt_end = (cnt_reg == CW'(2 * W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && cnt_end;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_end) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? W'(r_sh - {1'b0, dsr_reg}) : r_sh[W-1:0];
            dvd_reg <= {dvd_reg[2*W-2:0], ge};
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
